/* sv/markup_entity_to_utf8_decoder_top_assert.svh */
// assertion macros for the entity decoder checker
// expects clk and rst_n in the scope where a macro is used
`ifndef MARKUP_ENTITY_TO_UTF8_DECODER_TOP_ASSERT_SVH
`define MARKUP_ENTITY_TO_UTF8_DECODER_TOP_ASSERT_SVH

// consequent checked in the same cycle as the antecedent
`define MTU_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("entity decoder check failed");

// consequent checked in the cycle after the antecedent
`define MTU_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("entity decoder check failed");

`endif

/* sv/mtu_pkg.sv */
// shared types and constants of the markup entity to utf-8 decoder
// no dependencies
`default_nettype none

package mtu_pkg;

    // default store depth
    localparam int MAX_ENTITY_LEN_DEF = 32;

    // segment kinds
    localparam logic [1:0] KIND_NORMAL = 2'd0;
    localparam logic [1:0] KIND_ENTITY = 2'd1;
    localparam logic [1:0] KIND_NULL   = 2'd2;

    // characters
    localparam logic [7:0] CH_AMP   = 8'h26;
    localparam logic [7:0] CH_HASH  = 8'h23;
    localparam logic [7:0] CH_SEMI  = 8'h3B;
    localparam logic [7:0] CH_LT    = 8'h3C;
    localparam logic [7:0] CH_GT    = 8'h3E;
    localparam logic [7:0] CH_QUOT  = 8'h22;
    localparam logic [7:0] CH_APOS  = 8'h27;
    localparam logic [7:0] CH_0     = 8'h30;
    localparam logic [7:0] CH_9     = 8'h39;
    localparam logic [7:0] CH_UA    = 8'h41;
    localparam logic [7:0] CH_UF    = 8'h46;
    localparam logic [7:0] CH_UX    = 8'h58;
    localparam logic [7:0] CH_LA    = 8'h61;
    localparam logic [7:0] CH_LF    = 8'h66;
    localparam logic [7:0] CH_LX    = 8'h78;
    localparam logic [7:0] CH_M     = 8'h6D;
    localparam logic [7:0] CH_P     = 8'h70;
    localparam logic [7:0] CH_L     = 8'h6C;
    localparam logic [7:0] CH_G     = 8'h67;
    localparam logic [7:0] CH_T     = 8'h74;
    localparam logic [7:0] CH_Q     = 8'h71;
    localparam logic [7:0] CH_U     = 8'h75;
    localparam logic [7:0] CH_O     = 8'h6F;
    localparam logic [7:0] CH_S     = 8'h73;

    // code point limits
    localparam logic [20:0] CODE_SAT      = 21'h1FFFFF;
    localparam logic [20:0] CP_SURR_LO    = 21'h00D800;
    localparam logic [20:0] CP_SURR_HI    = 21'h00DFFF;
    localparam logic [20:0] CP_MAX        = 21'h10FFFF;
    localparam logic [20:0] CP_REPLACE    = 21'h00FFFD;
    localparam logic [20:0] CP_1BYTE_MAX  = 21'h00007F;
    localparam logic [20:0] CP_2BYTE_MAX  = 21'h0007FF;
    localparam logic [20:0] CP_3BYTE_MAX  = 21'h00FFFF;

    // utf-8 lead and continuation marks
    localparam logic [7:0] UTF8_LEAD2 = 8'hC0;
    localparam logic [7:0] UTF8_LEAD3 = 8'hE0;
    localparam logic [7:0] UTF8_LEAD4 = 8'hF0;
    localparam logic [7:0] UTF8_CONT  = 8'h80;

    // encoded replacement character
    localparam logic [7:0] UTF8_REPL_B0 = 8'hEF;
    localparam logic [7:0] UTF8_REPL_B1 = 8'hBF;
    localparam logic [7:0] UTF8_REPL_B2 = 8'hBD;

    // entity state seen by the resolver at the end of an entity
    typedef struct packed {
        logic        amp_first;
        logic [7:0]  nb1;
        logic [7:0]  nb2;
        logic [7:0]  nb3;
        logic [7:0]  nb4;
        logic [20:0] code;
        logic        hex;
        logic        digits_ok;
        logic        overflowed;
    } ent_ctx_t;

    // resolver verdict: raw replay, or up to four decoded bytes
    typedef struct packed {
        logic            replay;
        logic            ovf;
        logic [2:0]      len;
        logic [3:0][7:0] bytes;
    } dec_t;

endpackage

`default_nettype wire

/* sv/mtu_in_if.sv */
// input channel of the entity decoder: valid, ready and one text byte
// depends on nothing
`default_nettype none

interface mtu_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic [1:0] seg_kind;
    logic       seg_last;

    modport source (output valid, in_byte, seg_kind, seg_last, input ready);
    modport sink   (input valid, in_byte, seg_kind, seg_last, output ready);
endinterface

`default_nettype wire

/* sv/mtu_out_if.sv */
// output channel of the entity decoder: valid, ready and one utf-8 byte
// depends on nothing
`default_nettype none

interface mtu_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       run_last;
    logic       overflow;

    modport source (output valid, out_byte, run_last, overflow, input ready);
    modport sink   (input valid, out_byte, run_last, overflow, output ready);
endinterface

`default_nettype wire

/* sv/mtu_resolve.sv */
// end-of-entity resolver: named entity match, numeric check, utf-8 encoding
// depends on mtu_pkg
`default_nettype none

module mtu_resolve #(
    parameter int MAX_ENTITY_LEN = mtu_pkg::MAX_ENTITY_LEN_DEF
) (
    input  wire mtu_pkg::ent_ctx_t               ctx,
    input  wire logic [$clog2(MAX_ENTITY_LEN+1)-1:0] pos,
    input  wire logic [7:0]                      last_byte,
    output mtu_pkg::dec_t                        dec
);

    localparam int CW = $clog2(MAX_ENTITY_LEN + 1);

    logic        ends_ok;
    logic        numeric;
    logic        num_ok;
    logic        named_hit;
    logic [7:0]  named_val;
    logic [20:0] cp;
    logic [2:0]  u_len;
    logic [3:0][7:0] u_bytes;

    // framing: leading ampersand, trailing semicolon, at least two bytes
    assign ends_ok = ctx.amp_first && (pos >= CW'(1)) && (last_byte == mtu_pkg::CH_SEMI);

    // numeric reference needs at least one digit after the prefix
    assign numeric = (pos >= CW'(2)) && (ctx.nb1 == mtu_pkg::CH_HASH);
    assign num_ok  = ctx.digits_ok && (ctx.hex ? (pos > CW'(3)) : (pos > CW'(2)));

    // named entities
    always_comb
    begin
        named_hit = 1'b0;
        named_val = 8'h00;
        if (pos == CW'(4) && ctx.nb1 == mtu_pkg::CH_LA && ctx.nb2 == mtu_pkg::CH_M
            && ctx.nb3 == mtu_pkg::CH_P)
        begin
            named_hit = 1'b1;
            named_val = mtu_pkg::CH_AMP;
        end
        else if (pos == CW'(3) && ctx.nb1 == mtu_pkg::CH_L && ctx.nb2 == mtu_pkg::CH_T)
        begin
            named_hit = 1'b1;
            named_val = mtu_pkg::CH_LT;
        end
        else if (pos == CW'(3) && ctx.nb1 == mtu_pkg::CH_G && ctx.nb2 == mtu_pkg::CH_T)
        begin
            named_hit = 1'b1;
            named_val = mtu_pkg::CH_GT;
        end
        else if (pos == CW'(5) && ctx.nb1 == mtu_pkg::CH_Q && ctx.nb2 == mtu_pkg::CH_U
                 && ctx.nb3 == mtu_pkg::CH_O && ctx.nb4 == mtu_pkg::CH_T)
        begin
            named_hit = 1'b1;
            named_val = mtu_pkg::CH_QUOT;
        end
        else if (pos == CW'(5) && ctx.nb1 == mtu_pkg::CH_LA && ctx.nb2 == mtu_pkg::CH_P
                 && ctx.nb3 == mtu_pkg::CH_O && ctx.nb4 == mtu_pkg::CH_S)
        begin
            named_hit = 1'b1;
            named_val = mtu_pkg::CH_APOS;
        end
    end

    // surrogates and out-of-range values become the replacement character
    always_comb
    begin
        if ((ctx.code >= mtu_pkg::CP_SURR_LO && ctx.code <= mtu_pkg::CP_SURR_HI)
            || ctx.code > mtu_pkg::CP_MAX)
        begin
            cp = mtu_pkg::CP_REPLACE;
        end
        else
        begin
            cp = ctx.code;
        end
    end

    // utf-8 encoding
    always_comb
    begin
        u_bytes = '0;
        priority if (cp <= mtu_pkg::CP_1BYTE_MAX)
        begin
            u_len      = 3'd1;
            u_bytes[0] = cp[7:0];
        end
        else if (cp <= mtu_pkg::CP_2BYTE_MAX)
        begin
            u_len      = 3'd2;
            u_bytes[0] = mtu_pkg::UTF8_LEAD2 | {3'b000, cp[10:6]};
            u_bytes[1] = mtu_pkg::UTF8_CONT | {2'b00, cp[5:0]};
        end
        else if (cp <= mtu_pkg::CP_3BYTE_MAX)
        begin
            u_len      = 3'd3;
            u_bytes[0] = mtu_pkg::UTF8_LEAD3 | {4'b0000, cp[15:12]};
            u_bytes[1] = mtu_pkg::UTF8_CONT | {2'b00, cp[11:6]};
            u_bytes[2] = mtu_pkg::UTF8_CONT | {2'b00, cp[5:0]};
        end
        else
        begin
            u_len      = 3'd4;
            u_bytes[0] = mtu_pkg::UTF8_LEAD4 | {5'b00000, cp[20:18]};
            u_bytes[1] = mtu_pkg::UTF8_CONT | {2'b00, cp[17:12]};
            u_bytes[2] = mtu_pkg::UTF8_CONT | {2'b00, cp[11:6]};
            u_bytes[3] = mtu_pkg::UTF8_CONT | {2'b00, cp[5:0]};
        end
    end

    // verdict
    always_comb
    begin
        dec.ovf    = ctx.overflowed;
        dec.replay = 1'b1;
        dec.len    = 3'd1;
        dec.bytes  = '0;
        if (!ctx.overflowed && ends_ok)
        begin
            if (numeric)
            begin
                if (num_ok)
                begin
                    dec.replay = 1'b0;
                    dec.len    = u_len;
                    dec.bytes  = u_bytes;
                end
            end
            else if (named_hit)
            begin
                dec.replay   = 1'b0;
                dec.bytes[0] = named_val;
            end
        end
    end

endmodule

`default_nettype wire

/* sv/markup_entity_to_utf8_decoder_top.sv */
// Markup entity to UTF-8 decoder. Normal text bytes pass one per cycle while the output is
// not stalled; an entity byte that does not end its segment is taken and written to the
// entity store while it has room. A null segment end gives three bytes, a decoded entity end
// one to four bytes at one per cycle from a small shift buffer while the output is not
// stalled. For raw replay the store is a single memory with a registered read; a read is
// issued only once no earlier read is pending and the single output register is free.
// Input is held off while any result of an earlier transaction is still being produced.
// The store is not cleared after reset; every replayed entry was written by the same entity.
// depends on mtu_pkg, mtu_in_if, mtu_out_if, mtu_resolve
`default_nettype none

module markup_entity_to_utf8_decoder_top #(
    parameter int MAX_ENTITY_LEN = mtu_pkg::MAX_ENTITY_LEN_DEF
) (
    input wire logic clk,
    input wire logic rst_n,
    mtu_in_if.sink   in_ch,
    mtu_out_if.source out_ch
);

    localparam int CW = $clog2(MAX_ENTITY_LEN + 1);
    localparam int AW = $clog2(MAX_ENTITY_LEN);

    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_EMIT   = 2'd1;
    localparam logic [1:0] S_REPLAY = 2'd2;

    // entity store
    logic [7:0] store_mem [MAX_ENTITY_LEN];
    logic [7:0] mem_q_reg;

    logic [1:0]    state_reg, state_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic [20:0]   code_reg, code_next;
    logic          hex_reg, hex_next;
    logic          dok_reg, dok_next;
    logic          ovf_reg, ovf_next;
    logic          amp_reg, amp_next;
    logic [7:0]    nb1_reg, nb1_next;
    logic [7:0]    nb2_reg, nb2_next;
    logic [7:0]    nb3_reg, nb3_next;
    logic [7:0]    nb4_reg, nb4_next;

    logic          out_valid_reg, out_valid_next;
    logic [7:0]    out_byte_reg, out_byte_next;
    logic          out_last_reg, out_last_next;
    logic          out_ovf_reg, out_ovf_next;

    logic [2:0][7:0] emit_buf_reg, emit_buf_next;
    logic [1:0]      emit_cnt_reg, emit_cnt_next;

    logic [CW-1:0] rp_len_reg, rp_len_next;
    logic [CW-1:0] rp_idx_reg, rp_idx_next;
    logic          rp_ovf_reg, rp_ovf_next;
    logic          rd_pend_reg, rd_pend_next;
    logic          rd_last_reg, rd_last_next;

    logic          out_free;
    logic          in_ready;
    logic          acc;
    logic          is_ent;
    logic          is_null;
    logic          room;
    logic          wr_en;
    logic          rd_issue;
    logic [7:0]    c;
    logic          d_is;
    logic [3:0]    d_val;
    logic [25:0]   mul;
    logic [25:0]   v;
    logic [20:0]   code_upd;

    mtu_pkg::ent_ctx_t ctx;
    mtu_pkg::dec_t     dec;

    // handshake
    assign out_free = !out_valid_reg || out_ch.ready;
    assign in_ready = (state_reg == S_IDLE) && out_free;
    assign acc      = in_ch.valid && in_ready;
    assign is_ent   = (in_ch.seg_kind == mtu_pkg::KIND_ENTITY);
    assign is_null  = (in_ch.seg_kind == mtu_pkg::KIND_NULL);
    assign room     = (cnt_reg < CW'(MAX_ENTITY_LEN));
    assign wr_en    = acc && is_ent && room;
    assign rd_issue = (state_reg == S_REPLAY) && !rd_pend_reg && out_free
                      && (rp_idx_reg < rp_len_reg);

    assign in_ch.ready     = in_ready;
    assign out_ch.valid    = out_valid_reg;
    assign out_ch.out_byte = out_byte_reg;
    assign out_ch.run_last = out_last_reg;
    assign out_ch.overflow = out_ovf_reg;

    // digit classification
    assign c = in_ch.in_byte;
    always_comb
    begin
        d_is  = 1'b1;
        d_val = 4'd0;
        priority if (c >= mtu_pkg::CH_0 && c <= mtu_pkg::CH_9)
        begin
            d_val = 4'(c - mtu_pkg::CH_0);
        end
        else if (hex_reg && c >= mtu_pkg::CH_LA && c <= mtu_pkg::CH_LF)
        begin
            d_val = 4'(c - mtu_pkg::CH_LA + 8'd10);
        end
        else if (hex_reg && c >= mtu_pkg::CH_UA && c <= mtu_pkg::CH_UF)
        begin
            d_val = 4'(c - mtu_pkg::CH_UA + 8'd10);
        end
        else
        begin
            d_is = 1'b0;
        end
    end

    // accumulate one digit, saturating
    assign mul = hex_reg ? {1'b0, code_reg, 4'b0000}
                         : ({2'b00, code_reg, 3'b000} + {4'b0000, code_reg, 1'b0});
    assign v   = mul + {22'd0, d_val};
    assign code_upd = (v > {5'd0, mtu_pkg::CODE_SAT}) ? mtu_pkg::CODE_SAT : v[20:0];

    // resolver view of the entity
    always_comb
    begin
        ctx.amp_first  = amp_reg;
        ctx.nb1        = nb1_reg;
        ctx.nb2        = nb2_reg;
        ctx.nb3        = nb3_reg;
        ctx.nb4        = nb4_reg;
        ctx.code       = code_reg;
        ctx.hex        = hex_reg;
        ctx.digits_ok  = dok_reg;
        ctx.overflowed = ovf_reg || !room;
    end

    mtu_resolve #(
        .MAX_ENTITY_LEN (MAX_ENTITY_LEN)
    ) u_resolve (
        .ctx       (ctx),
        .pos       (cnt_reg),
        .last_byte (in_ch.in_byte),
        .dec       (dec)
    );

    // control and datapath next state
    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        code_next      = code_reg;
        hex_next       = hex_reg;
        dok_next       = dok_reg;
        ovf_next       = ovf_reg;
        amp_next       = amp_reg;
        nb1_next       = nb1_reg;
        nb2_next       = nb2_reg;
        nb3_next       = nb3_reg;
        nb4_next       = nb4_reg;
        out_valid_next = out_valid_reg && !out_ch.ready;
        out_byte_next  = out_byte_reg;
        out_last_next  = out_last_reg;
        out_ovf_next   = out_ovf_reg;
        emit_buf_next  = emit_buf_reg;
        emit_cnt_next  = emit_cnt_reg;
        rp_len_next    = rp_len_reg;
        rp_idx_next    = rp_idx_reg;
        rp_ovf_next    = rp_ovf_reg;
        rd_pend_next   = rd_issue;
        rd_last_next   = rd_last_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (acc)
                begin
                    if (is_ent)
                    begin
                        // store the byte and track the prefix
                        if (room)
                        begin
                            cnt_next = cnt_reg + CW'(1);
                            if (cnt_reg == CW'(0)) amp_next = (c == mtu_pkg::CH_AMP);
                            if (cnt_reg == CW'(1)) nb1_next = c;
                            if (cnt_reg == CW'(2)) nb2_next = c;
                            if (cnt_reg == CW'(3)) nb3_next = c;
                            if (cnt_reg == CW'(4)) nb4_next = c;
                            // digits of a numeric reference
                            if (!in_ch.seg_last && cnt_reg >= CW'(2)
                                && nb1_reg == mtu_pkg::CH_HASH)
                            begin
                                if (cnt_reg == CW'(2)
                                    && (c == mtu_pkg::CH_LX || c == mtu_pkg::CH_UX))
                                begin
                                    hex_next = 1'b1;
                                end
                                else if (d_is)
                                begin
                                    code_next = code_upd;
                                end
                                else
                                begin
                                    dok_next = 1'b0;
                                end
                            end
                        end
                        else
                        begin
                            ovf_next = 1'b1;
                        end

                        // end of entity: decode or replay, then start afresh
                        if (in_ch.seg_last)
                        begin
                            cnt_next  = '0;
                            code_next = '0;
                            hex_next  = 1'b0;
                            dok_next  = 1'b1;
                            ovf_next  = 1'b0;
                            if (dec.replay)
                            begin
                                state_next  = S_REPLAY;
                                rp_len_next = room ? (cnt_reg + CW'(1))
                                                   : CW'(MAX_ENTITY_LEN);
                                rp_idx_next = '0;
                                rp_ovf_next = dec.ovf;
                            end
                            else
                            begin
                                out_valid_next = 1'b1;
                                out_byte_next  = dec.bytes[0];
                                out_last_next  = (dec.len == 3'd1);
                                out_ovf_next   = 1'b0;
                                emit_buf_next  = dec.bytes[3:1];
                                emit_cnt_next  = 2'(dec.len - 3'd1);
                                if (dec.len != 3'd1) state_next = S_EMIT;
                            end
                        end
                    end
                    else if (is_null)
                    begin
                        // replacement character at the segment end
                        if (in_ch.seg_last)
                        begin
                            out_valid_next   = 1'b1;
                            out_byte_next    = mtu_pkg::UTF8_REPL_B0;
                            out_last_next    = 1'b0;
                            out_ovf_next     = 1'b0;
                            emit_buf_next[0] = mtu_pkg::UTF8_REPL_B1;
                            emit_buf_next[1] = mtu_pkg::UTF8_REPL_B2;
                            emit_cnt_next    = 2'd2;
                            state_next       = S_EMIT;
                        end
                    end
                    else
                    begin
                        // normal text passes through
                        out_valid_next = 1'b1;
                        out_byte_next  = c;
                        out_last_next  = 1'b1;
                        out_ovf_next   = 1'b0;
                    end
                end
            end

            S_EMIT:
            begin
                // drain the shift buffer
                if (out_free)
                begin
                    out_valid_next   = 1'b1;
                    out_byte_next    = emit_buf_reg[0];
                    out_last_next    = (emit_cnt_reg == 2'd1);
                    out_ovf_next     = 1'b0;
                    emit_buf_next[0] = emit_buf_reg[1];
                    emit_buf_next[1] = emit_buf_reg[2];
                    emit_cnt_next    = emit_cnt_reg - 2'd1;
                    if (emit_cnt_reg == 2'd1) state_next = S_IDLE;
                end
            end

            S_REPLAY:
            begin
                // read issue, data goes through mem_q_reg into the output register
                if (rd_issue)
                begin
                    rp_idx_next  = rp_idx_reg + CW'(1);
                    rd_last_next = ((rp_idx_reg + CW'(1)) == rp_len_reg);
                end
                if (rd_pend_reg)
                begin
                    out_valid_next = 1'b1;
                    out_byte_next  = mem_q_reg;
                    out_last_next  = rd_last_reg;
                    out_ovf_next   = rp_ovf_reg;
                    if (rd_last_reg) state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // store write and registered read
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            store_mem[cnt_reg[AW-1:0]] <= in_ch.in_byte;
        end
        if (rd_issue)
        begin
            mem_q_reg <= store_mem[rp_idx_reg[AW-1:0]];
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cnt_reg       <= '0;
            code_reg      <= '0;
            hex_reg       <= 1'b0;
            dok_reg       <= 1'b1;
            ovf_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
            emit_cnt_reg  <= '0;
            rp_len_reg    <= '0;
            rp_idx_reg    <= '0;
            rd_pend_reg   <= 1'b0;
            rd_last_reg   <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            code_reg      <= code_next;
            hex_reg       <= hex_next;
            dok_reg       <= dok_next;
            ovf_reg       <= ovf_next;
            out_valid_reg <= out_valid_next;
            emit_cnt_reg  <= emit_cnt_next;
            rp_len_reg    <= rp_len_next;
            rp_idx_reg    <= rp_idx_next;
            rd_pend_reg   <= rd_pend_next;
            rd_last_reg   <= rd_last_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        amp_reg      <= amp_next;
        nb1_reg      <= nb1_next;
        nb2_reg      <= nb2_next;
        nb3_reg      <= nb3_next;
        nb4_reg      <= nb4_next;
        out_byte_reg <= out_byte_next;
        out_last_reg <= out_last_next;
        out_ovf_reg  <= out_ovf_next;
        emit_buf_reg <= emit_buf_next;
        rp_ovf_reg   <= rp_ovf_next;
    end

endmodule

`default_nettype wire

/* sv/mtu_checker.sv */
// port-level checks of the entity decoder, bound to the top level
// depends on mtu_pkg and markup_entity_to_utf8_decoder_top_assert.svh
`default_nettype none

`include "markup_entity_to_utf8_decoder_top_assert.svh"

module mtu_checker (
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       in_valid,
    input wire logic       in_ready,
    input wire logic [7:0] in_byte,
    input wire logic [1:0] in_kind,
    input wire logic       in_last,
    input wire logic       out_valid,
    input wire logic       out_ready,
    input wire logic [7:0] out_byte,
    input wire logic       out_last,
    input wire logic       out_ovf
);

    logic in_acc;
    assign in_acc = in_valid && in_ready;

    // a stalled result holds
    `MTU_ASSERT_NEXT(a_out_hold, out_valid && !out_ready,
        out_valid && $stable(out_byte) && $stable(out_last) && $stable(out_ovf))

    // no transaction taken while a result is stalled
    `MTU_ASSERT_SAME(a_in_blocked, out_valid && !out_ready, !in_ready)

    // normal text shows up on the next cycle, alone
    `MTU_ASSERT_NEXT(a_pass_through,
        in_acc && in_kind != mtu_pkg::KIND_ENTITY && in_kind != mtu_pkg::KIND_NULL,
        out_valid && out_byte == $past(in_byte) && out_last && !out_ovf)

    // null segment end starts the replacement character
    `MTU_ASSERT_NEXT(a_null_lead, in_acc && in_kind == mtu_pkg::KIND_NULL && in_last,
        out_valid && out_byte == mtu_pkg::UTF8_REPL_B0 && !out_last && !out_ovf)

    // an unfinished entity byte gives no result
    `MTU_ASSERT_NEXT(a_entity_quiet, in_acc && in_kind == mtu_pkg::KIND_ENTITY && !in_last,
        !out_valid)

endmodule

bind markup_entity_to_utf8_decoder_top mtu_checker u_mtu_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .in_byte   (in_ch.in_byte),
    .in_kind   (in_ch.seg_kind),
    .in_last   (in_ch.seg_last),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .out_byte  (out_ch.out_byte),
    .out_last  (out_ch.run_last),
    .out_ovf   (out_ch.overflow)
);

`default_nettype wire

/* sim/mtu_utf8_stream_check.sv */
// stream checker for the markup entity to utf-8 decoder: predicts the output bytes of
// every accepted input transaction and compares them with what the block emits
// depends on mtu_pkg, mtu_in_if, mtu_out_if
module mtu_utf8_stream_check (
    input  wire logic clk,
    input  wire logic rst_n,
    mtu_in_if         in_ch,
    mtu_out_if        out_ch,
    output int        fail_count,
    output int        pending,
    output int        in_count,
    output int        out_count,
    output int        decoded_count,
    output int        raw_count,
    output int        overflow_count
);
    timeunit 1ns;
    timeprecision 1ps;

    import mtu_pkg::*;

    localparam int STORE_DEPTH = MAX_ENTITY_LEN_DEF;
    localparam int MAX_PRINTED = 100;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
        logic       ovf;
    } utf8_res_t;

    // shadow copy of the entity state
    logic [7:0]  ent_store [STORE_DEPTH];
    int unsigned ent_len = 0;
    logic [20:0] code_val = '0;
    logic        hex_ref = 1'b0;
    logic        digits_good = 1'b1;
    logic        store_full = 1'b0;

    utf8_res_t utf8_due_q [$];
    utf8_res_t burst [$];

    initial
    begin
        fail_count = 0;
        pending = 0;
        in_count = 0;
        out_count = 0;
        decoded_count = 0;
        raw_count = 0;
        overflow_count = 0;
    end

    task automatic report_mismatch(input string msg);
        fail_count++;
        if (fail_count <= MAX_PRINTED)
            $display("[%0t] mismatch: %s", $time, msg);
    endtask

    task automatic add_byte(input logic [7:0] b, input logic ovf);
        utf8_res_t r;
        r.data = b;
        r.last = 1'b0;
        r.ovf  = ovf;
        burst.push_back(r);
    endtask

    task automatic replay_store(input int unsigned n, input logic ovf);
        for (int unsigned i = 0; i < n && i < STORE_DEPTH; i++)
            add_byte(ent_store[i], ovf);
    endtask

    // utf-8 encoding with surrogates and out-of-range values replaced
    task automatic emit_code_point(input logic [20:0] cp_in);
        logic [20:0] cp;
        cp = cp_in;
        if ((cp >= CP_SURR_LO && cp <= CP_SURR_HI) || cp > CP_MAX)
            cp = CP_REPLACE;
        if (cp <= CP_1BYTE_MAX)
        begin
            add_byte(cp[7:0], 1'b0);
        end
        else if (cp <= CP_2BYTE_MAX)
        begin
            add_byte(UTF8_LEAD2 | {3'b000, cp[10:6]}, 1'b0);
            add_byte(UTF8_CONT | {2'b00, cp[5:0]}, 1'b0);
        end
        else if (cp <= CP_3BYTE_MAX)
        begin
            add_byte(UTF8_LEAD3 | {4'b0000, cp[15:12]}, 1'b0);
            add_byte(UTF8_CONT | {2'b00, cp[11:6]}, 1'b0);
            add_byte(UTF8_CONT | {2'b00, cp[5:0]}, 1'b0);
        end
        else
        begin
            add_byte(UTF8_LEAD4 | {5'b00000, cp[20:18]}, 1'b0);
            add_byte(UTF8_CONT | {2'b00, cp[17:12]}, 1'b0);
            add_byte(UTF8_CONT | {2'b00, cp[11:6]}, 1'b0);
            add_byte(UTF8_CONT | {2'b00, cp[5:0]}, 1'b0);
        end
    endtask

    // numeric reference digits accumulate with saturation
    task automatic take_digit(input int unsigned pos, input logic [7:0] c);
        int unsigned digit;
        int unsigned acc;
        if (pos < 2 || ent_store[1] != CH_HASH)
            return;
        if (pos == 2 && (c == CH_LX || c == CH_UX))
        begin
            hex_ref = 1'b1;
            return;
        end
        if (c >= CH_0 && c <= CH_9)
            digit = c - CH_0;
        else if (hex_ref && c >= CH_LA && c <= CH_LF)
            digit = c - CH_LA + 10;
        else if (hex_ref && c >= CH_UA && c <= CH_UF)
            digit = c - CH_UA + 10;
        else
        begin
            digits_good = 1'b0;
            return;
        end
        acc = code_val * (hex_ref ? 32'd16 : 32'd10) + digit;
        code_val = (acc > CODE_SAT) ? CODE_SAT : acc[20:0];
    endtask

    // named entities: lt gt amp quot apos
    function automatic logic named_lookup(input int unsigned n, output logic [7:0] ch);
        ch = '0;
        case (n)
            4:
            begin
                if (ent_store[1] == CH_L && ent_store[2] == CH_T)
                begin
                    ch = CH_LT;
                    return 1'b1;
                end
                if (ent_store[1] == CH_G && ent_store[2] == CH_T)
                begin
                    ch = CH_GT;
                    return 1'b1;
                end
            end
            5:
            begin
                if (ent_store[1] == CH_LA && ent_store[2] == CH_M && ent_store[3] == CH_P)
                begin
                    ch = CH_AMP;
                    return 1'b1;
                end
            end
            6:
            begin
                if (ent_store[1] == CH_Q && ent_store[2] == CH_U && ent_store[3] == CH_O &&
                    ent_store[4] == CH_T)
                begin
                    ch = CH_QUOT;
                    return 1'b1;
                end
                if (ent_store[1] == CH_LA && ent_store[2] == CH_P && ent_store[3] == CH_O &&
                    ent_store[4] == CH_S)
                begin
                    ch = CH_APOS;
                    return 1'b1;
                end
            end
            default: ;
        endcase
        return 1'b0;
    endfunction

    // decision at the end of an entity segment
    task automatic close_entity();
        int unsigned n;
        logic [7:0]  ch;
        n = ent_len;
        if (store_full)
        begin
            replay_store(n, 1'b1);
            overflow_count++;
        end
        else if (n < 2 || ent_store[0] != CH_AMP || ent_store[n - 1] != CH_SEMI)
        begin
            replay_store(n, 1'b0);
            raw_count++;
        end
        else if (n > 2 && ent_store[1] == CH_HASH)
        begin
            if (n > 3 + hex_ref && digits_good)
            begin
                emit_code_point(code_val);
                decoded_count++;
            end
            else
            begin
                replay_store(n, 1'b0);
                raw_count++;
            end
        end
        else if (named_lookup(n, ch))
        begin
            add_byte(ch, 1'b0);
            decoded_count++;
        end
        else
        begin
            replay_store(n, 1'b0);
            raw_count++;
        end
    endtask

    task automatic clear_entity();
        ent_len     = 0;
        code_val    = '0;
        hex_ref     = 1'b0;
        digits_good = 1'b1;
        store_full  = 1'b0;
    endtask

    // expected output bytes of one input transaction
    task automatic decode_item(input logic [7:0] b, input logic [1:0] kind, input logic last);
        int unsigned pos;
        utf8_res_t   r;
        burst.delete();
        if (kind == KIND_ENTITY)
        begin
            pos = ent_len;
            if (pos < STORE_DEPTH)
            begin
                ent_store[pos] = b;
                ent_len = pos + 1;
                if (!last)
                    take_digit(pos, b);
            end
            else
            begin
                store_full = 1'b1;
            end
            if (last)
            begin
                close_entity();
                clear_entity();
            end
        end
        else if (kind == KIND_NULL)
        begin
            if (last)
            begin
                add_byte(UTF8_REPL_B0, 1'b0);
                add_byte(UTF8_REPL_B1, 1'b0);
                add_byte(UTF8_REPL_B2, 1'b0);
            end
        end
        else
        begin
            add_byte(b, 1'b0);
        end
        if (burst.size() > 0)
        begin
            r = burst.pop_back();
            r.last = 1'b1;
            burst.push_back(r);
        end
        foreach (burst[i])
            utf8_due_q.push_back(burst[i]);
    endtask

    // watch both channels
    always @(posedge clk or negedge rst_n)
    begin
        utf8_res_t want;
        if (!rst_n)
        begin
            clear_entity();
            utf8_due_q.delete();
        end
        else
        begin
            if (in_ch.valid && in_ch.ready)
            begin
                in_count++;
                decode_item(in_ch.in_byte, in_ch.seg_kind, in_ch.seg_last);
            end
            if (out_ch.valid && out_ch.ready)
            begin
                out_count++;
                if (utf8_due_q.size() == 0)
                begin
                    report_mismatch($sformatf("unexpected output byte %02h last %b ovf %b",
                        out_ch.out_byte, out_ch.run_last, out_ch.overflow));
                end
                else
                begin
                    want = utf8_due_q.pop_front();
                    if (out_ch.out_byte !== want.data || out_ch.run_last !== want.last ||
                        out_ch.overflow !== want.ovf)
                        report_mismatch($sformatf(
                            "output %0d: got byte %02h last %b ovf %b, want %02h %b %b",
                            out_count, out_ch.out_byte, out_ch.run_last, out_ch.overflow,
                            want.data, want.last, want.ovf));
                end
            end
        end
        pending = utf8_due_q.size();
    end

endmodule

/* sim/markup_entity_to_utf8_decoder_top_test.sv */
// top of the entity decoder testbench: clock, reset, text stimulus and the verdict
// depends on mtu_pkg, mtu_in_if, mtu_out_if, markup_entity_to_utf8_decoder_top and
// mtu_utf8_stream_check
module markup_entity_to_utf8_decoder_top_test;
    timeunit 1ns;
    timeprecision 1ps;

    import mtu_pkg::*;

    localparam logic [1:0] KIND_SPARE  = 2'd3;
    localparam int         STORE_DEPTH = MAX_ENTITY_LEN_DEF;
    localparam int         PHASE_ITEMS = 55;
    localparam int         DRAIN_CYCLES = 100;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    int idle_pct = 0;
    int stall_pct = 0;
    int n_sent = 0;

    int fail_count;
    int pending;
    int in_count;
    int out_count;
    int decoded_count;
    int raw_count;
    int overflow_count;

    logic [7:0] ent_bytes [$];

    mtu_in_if  in_ch ();
    mtu_out_if out_ch ();

    markup_entity_to_utf8_decoder_top dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .out_ch (out_ch)
    );

    mtu_utf8_stream_check stream_check (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_ch          (in_ch),
        .out_ch         (out_ch),
        .fail_count     (fail_count),
        .pending        (pending),
        .in_count       (in_count),
        .out_count      (out_count),
        .decoded_count  (decoded_count),
        .raw_count      (raw_count),
        .overflow_count (overflow_count)
    );

    // 20 ns clock
    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    // receiver back-pressure
    always @(posedge clk)
        out_ch.ready <= ($urandom_range(99) >= stall_pct);

    // watchdog
    initial
    begin
        #5_000_000;
        $display("markup_entity_to_utf8_decoder_top_test failed");
        $finish;
    end

    // one input transaction, with random idle cycles ahead of it
    task automatic send_byte(input logic [7:0] b, input logic [1:0] kind, input logic last);
        while ($urandom_range(99) < idle_pct)
        begin
            in_ch.valid    <= 1'b0;
            in_ch.in_byte  <= 8'($urandom);
            in_ch.seg_kind <= 2'($urandom);
            in_ch.seg_last <= 1'($urandom);
            @(posedge clk);
        end
        in_ch.valid    <= 1'b1;
        in_ch.in_byte  <= b;
        in_ch.seg_kind <= kind;
        in_ch.seg_last <= last;
        @(posedge clk);
        while (!in_ch.ready)
            @(posedge clk);
        n_sent++;
    endtask

    task automatic push_text(input string s);
        for (int i = 0; i < s.len(); i++)
            ent_bytes.push_back(s[i]);
    endtask

    // null-character segment of one to three bytes
    task automatic send_null(input int len);
        for (int i = 0; i < len; i++)
            send_byte(8'($urandom), KIND_NULL, i == len - 1);
    endtask

    // a normal, spare-kind or null byte dropped in while an entity is open
    task automatic send_foreign();
        case ($urandom_range(2))
            0: send_byte(8'($urandom), KIND_NORMAL, 1'($urandom));
            1: send_byte(8'($urandom), KIND_SPARE, 1'($urandom));
            default: send_null(1);
        endcase
    endtask

    // ship the staged entity, last byte marked
    task automatic send_entity(input logic mix);
        int cut;
        int len;
        len = ent_bytes.size();
        cut = -1;
        if (mix && len > 1 && $urandom_range(99) < 12)
            cut = $urandom_range(len - 1, 1);
        for (int i = 0; i < len; i++)
        begin
            if (i == cut)
                send_foreign();
            send_byte(ent_bytes[i], KIND_ENTITY, i == len - 1);
        end
        ent_bytes.delete();
    endtask

    function automatic int unsigned pick_code_point();
        int unsigned edges [15];
        edges = '{32'h0, 32'h7F, 32'h80, 32'h7FF, 32'h800, 32'hD7FF, 32'hD800, 32'hDFFF,
                  32'hE000, 32'hFFFD, 32'hFFFF, 32'h10000, 32'h10FFFF, 32'h110000, 32'h1FFFFF};
        case ($urandom_range(9))
            0: return $urandom_range(32'h7F);
            1: return $urandom_range(32'h7FF, 32'h80);
            2: return $urandom_range(32'hFFFF, 32'h800);
            3, 4: return $urandom_range(32'h10FFFF, 32'h10000);
            5: return $urandom_range(32'hDFFF, 32'hD800);
            6: return $urandom_range(32'h1FFFFF, 32'h110000);
            default: return edges[$urandom_range(14)];
        endcase
    endfunction

    // hex digits with mixed case and optional leading zeros
    function automatic string hex_digits(input int unsigned v);
        string s;
        s = $sformatf("%0h", v);
        for (int i = 0; i < s.len(); i++)
            if (s[i] >= CH_LA && $urandom_range(1))
                s[i] = s[i] - 8'h20;
        if ($urandom_range(3) == 0)
            s = {"00", s};
        return s;
    endfunction

    function automatic string name_of(input int idx);
        case (idx)
            0: return "amp";
            1: return "lt";
            2: return "gt";
            3: return "quot";
            default: return "apos";
        endcase
    endfunction

    // stage one random entity segment in ent_bytes
    task automatic build_entity();
        string nm;
        string bad;
        int    len;
        int    pick;
        pick = $urandom_range(99);
        if (pick < 25)
        begin
            // named reference, sometimes damaged
            nm = name_of($urandom_range(4));
            case ($urandom_range(9))
                0: push_text({"&", nm});
                1: push_text({"&", nm.toupper(), ";"});
                2: push_text({"&", nm.substr(0, nm.len() - 2), ";"});
                3: push_text({"&", nm, "x;"});
                4: push_text("&;");
                default: push_text({"&", nm, ";"});
            endcase
        end
        else if (pick < 50)
        begin
            push_text({"&#", $sformatf("%0d", pick_code_point()), ";"});
        end
        else if (pick < 70)
        begin
            push_text({($urandom_range(1) ? "&#x" : "&#X"), hex_digits(pick_code_point()), ";"});
        end
        else if (pick < 80)
        begin
            // malformed numeric reference
            case ($urandom_range(5))
                0: push_text("&#;");
                1: push_text("&#x;");
                2:
                begin
                    case ($urandom_range(3))
                        0: bad = "g";
                        1: bad = "a";
                        2: bad = "-";
                        default: bad = " ";
                    endcase
                    push_text({"&#1", bad, "2;"});
                end
                3: push_text({"&#x", ($urandom_range(1) ? "G1" : "1z"), ";"});
                4: push_text({"&#", $sformatf("%0d", pick_code_point())});
                default: push_text("&#");
            endcase
        end
        else if (pick < 88)
        begin
            // long digit strings push the value into saturation
            push_text("&#");
            if ($urandom_range(1))
                push_text("x");
            len = $urandom_range(20, 7);
            for (int i = 0; i < len; i++)
                ent_bytes.push_back(8'(CH_0 + $urandom_range(9)));
            push_text(";");
        end
        else if (pick < 95)
        begin
            len = $urandom_range(8, 1);
            for (int i = 0; i < len; i++)
                ent_bytes.push_back(8'($urandom));
            if ($urandom_range(1))
                ent_bytes[0] = CH_AMP;
        end
        else
        begin
            // around the store depth, mostly past it
            len = $urandom_range(STORE_DEPTH + 8, STORE_DEPTH - 1);
            ent_bytes.push_back(CH_AMP);
            for (int i = 1; i < len - 1; i++)
                ent_bytes.push_back(8'($urandom));
            ent_bytes.push_back($urandom_range(1) ? CH_SEMI : 8'($urandom));
        end
    endtask

    // one random segment of any kind
    task automatic send_segment();
        int pick;
        pick = $urandom_range(99);
        if (pick < 22)
        begin
            send_byte(8'($urandom), ($urandom_range(6) == 0) ? KIND_SPARE : KIND_NORMAL,
                      1'($urandom));
        end
        else if (pick < 30)
        begin
            send_null($urandom_range(3, 1));
        end
        else
        begin
            build_entity();
            send_entity(1'b1);
        end
    endtask

    // stimulus and verdict
    initial
    begin
        int target;
        in_ch.valid    = 1'b0;
        in_ch.in_byte  = '0;
        in_ch.seg_kind = KIND_NORMAL;
        in_ch.seg_last = 1'b0;
        out_ch.ready   = 1'b0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: byte extremes, spare kind, null segment, named and numeric references, lone semicolon
        send_byte(8'h00, KIND_NORMAL, 1'b0);
        send_byte(8'hFF, KIND_NORMAL, 1'b1);
        send_byte(8'hA5, KIND_SPARE, 1'b1);
        send_null(2);
        push_text("&gt;");
        send_entity(1'b0);
        push_text("&#65;");
        send_entity(1'b0);
        push_text("&#xD800;");
        send_entity(1'b0);
        push_text(";");
        send_entity(1'b0);

        // random phases with different idle and stall mixes
        for (int phase = 0; phase < 4; phase++)
        begin
            case (phase)
                0:
                begin
                    idle_pct  = 0;
                    stall_pct = 0;
                end
                1:
                begin
                    idle_pct  = 56;
                    stall_pct = 0;
                end
                2:
                begin
                    idle_pct  = 0;
                    stall_pct = 56;
                end
                default:
                begin
                    idle_pct  = 35;
                    stall_pct = 35;
                end
            endcase
            target = n_sent + PHASE_ITEMS;
            while (n_sent < target)
                send_segment();
        end
        in_ch.valid <= 1'b0;

        // drain
        while (pending != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("covered %0d input and %0d output transactions", in_count, out_count);
        $display("entities: %0d decoded, %0d replayed raw, %0d past the store",
            decoded_count, raw_count, overflow_count);
        if (fail_count == 0 && pending == 0)
            $display("markup_entity_to_utf8_decoder_top_test passed");
        else
            $display("markup_entity_to_utf8_decoder_top_test failed");
        $finish;
    end

endmodule
